// ----- hw/rtl/qtol_pkg.sv -----
// ----------------------------------------------------------------------------
// Quadtree tile offset locator package
// Shared payload types, status and command codes, table sizing and the
// quadtree index helper.
// ----------------------------------------------------------------------------
package qtol_pkg;

	// Table sizing
	localparam int TABLE_ENTRIES = 1366;
	localparam int ENTRY_W       = 11;
	localparam int WORD_W        = 32;

	localparam logic [ENTRY_W-1:0] LAST_ENTRY  = ENTRY_W'(TABLE_ENTRIES - 1);
	localparam logic [ENTRY_W-1:0] ENTRY_COUNT = ENTRY_W'(TABLE_ENTRIES);

	// Header and file limits
	localparam logic [WORD_W-1:0] MIN_FILE_BYTES  = WORD_W'(8 + 4 * TABLE_ENTRIES);
	localparam logic [7:0]        MAX_VERSION     = 8'd2;
	localparam logic [4:0]        MAX_ZOOM        = 5'd17;
	localparam logic [WORD_W-1:0] MIN_REAL_OFFSET = WORD_W'(4);

	// Base zoom levels
	localparam logic [3:0] BASE_ZOOM_LO  = 4'd0;
	localparam logic [3:0] BASE_ZOOM_MID = 4'd6;
	localparam logic [3:0] BASE_ZOOM_HI  = 4'd12;
	localparam logic [4:0] ZOOM_MID_MIN  = 5'd6;
	localparam logic [4:0] ZOOM_MID_MAX  = 5'd11;

	// Command codes
	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_LOCATE = 1'b1;

	// Configuration register indexes
	localparam logic CFG_TILESET_BYTES  = 1'b0;
	localparam logic CFG_HEADER_VERSION = 1'b1;

	// Status codes
	localparam logic [2:0] ST_EMPTY       = 3'd0;
	localparam logic [2:0] ST_SEA         = 3'd1;
	localparam logic [2:0] ST_LAND        = 3'd2;
	localparam logic [2:0] ST_TRANSPARENT = 3'd3;
	localparam logic [2:0] ST_FOUND       = 3'd4;
	localparam logic [2:0] ST_ERROR       = 3'd5;

	typedef struct packed {
		logic              cmd;
		logic [ENTRY_W-1:0] load_index;
		logic [WORD_W-1:0]  load_value;
		logic [4:0]         zoom;
		logic [16:0]        tile_x;
		logic [16:0]        tile_y;
	} qtol_req_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [ENTRY_W-1:0] tile_index;
		logic [3:0]         base_zoom;
		logic [16:0]        base_x;
		logic [16:0]        base_y;
		logic [WORD_W-1:0]  tile_offset;
		logic [WORD_W-1:0]  tile_length;
	} qtol_rsp_t;

	typedef enum logic [1:0] {
		LOC_IDLE,
		LOC_ENTRY,
		LOC_SCAN,
		LOC_DONE
	} qtol_state_t;

	// Pyramid prefix plus row and column inside the base tile (dz up to 5)
	function automatic logic [ENTRY_W-1:0] quad_index(
		input logic [2:0] dz,
		input logic [4:0] col,
		input logic [4:0] row
	);
		logic [ENTRY_W-1:0] prefix;
		logic [4:0]         mask;
		logic [ENTRY_W-1:0] row_part;
		logic [ENTRY_W-1:0] col_part;
		unique case (dz)
			3'd0:    prefix = ENTRY_W'(0);
			3'd1:    prefix = ENTRY_W'(1);
			3'd2:    prefix = ENTRY_W'(5);
			3'd3:    prefix = ENTRY_W'(21);
			3'd4:    prefix = ENTRY_W'(85);
			3'd5:    prefix = ENTRY_W'(341);
			default: prefix = ENTRY_W'(0);
		endcase
		mask     = 5'((6'd1 << dz) - 6'd1);
		row_part = ENTRY_W'(row & mask) << dz;
		col_part = ENTRY_W'(col & mask);
		return prefix + row_part + col_part;
	endfunction

endpackage

// ----- hw/rtl/quadtree_tile_offset_locator_unit.sv -----
// ----------------------------------------------------------------------------
// Quadtree tile offset locator
// Holds one tileset offset table in a synchronous RAM and answers where a
// requested tile lies in that tileset, with its byte offset and length.
// ----------------------------------------------------------------------------
// Load: no result. Locate: reads the tile's own entry, then scans the entries
// after it through the single read port of the offset table, one entry per
// cycle, until a real offset or the last entry is reached.
// One item is in work at a time; a result waits in the output register.
// Reset clears control state and both configuration registers; the offset
// table is not cleared and is undefined until loaded.
module quadtree_tile_offset_locator_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	// request channel
	input  logic                          req_valid,
	output logic                          req_stall,
	input  qtol_pkg::qtol_req_t           req,
	// response channel
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output qtol_pkg::qtol_rsp_t           rsp,
	// configuration write channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_index,
	input  logic [qtol_pkg::WORD_W-1:0]   cfg_data
);

	qtol_pkg::qtol_state_t state_q, state_d;

	logic [qtol_pkg::WORD_W-1:0]  tileset_bytes_q;
	logic [7:0]                   header_version_q;

	logic [qtol_pkg::WORD_W-1:0]  mem_q [qtol_pkg::TABLE_ENTRIES];
	logic [qtol_pkg::WORD_W-1:0]  rd_data_q;
	logic                         rd_en;
	logic [qtol_pkg::ENTRY_W-1:0] rd_addr;
	logic                         mem_we;

	logic [qtol_pkg::ENTRY_W-1:0] scan_addr_q;
	logic                         last_issued_q;
	logic [qtol_pkg::WORD_W-1:0]  entry_q;
	logic                         scan_step;

	qtol_pkg::qtol_rsp_t          pend_q;
	qtol_pkg::qtol_rsp_t          rsp_q;
	logic                         rsp_valid_q;

	logic                         req_xfer;
	logic                         locate_start;
	logic                         out_load;
	logic                         fin;
	logic [2:0]                   fin_status;
	logic [qtol_pkg::WORD_W-1:0]  fin_off;
	logic [qtol_pkg::WORD_W-1:0]  fin_len;

	// locate front end
	logic [3:0]                   bz;
	logic [4:0]                   dz;
	logic                         locate_ok;
	logic [qtol_pkg::ENTRY_W-1:0] loc_idx;

	assign req_stall = (state_q != qtol_pkg::LOC_IDLE);
	assign req_xfer  = req_valid && !req_stall;
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Pick base tileset and quadtree index for the incoming request
	always_comb begin
		if (req.zoom < qtol_pkg::ZOOM_MID_MIN) begin
			bz = qtol_pkg::BASE_ZOOM_LO;
		end else if (req.zoom > qtol_pkg::ZOOM_MID_MAX) begin
			bz = qtol_pkg::BASE_ZOOM_HI;
		end else begin
			bz = qtol_pkg::BASE_ZOOM_MID;
		end
		dz        = req.zoom - 5'(bz);
		locate_ok = (tileset_bytes_q >= qtol_pkg::MIN_FILE_BYTES)
			&& (header_version_q <= qtol_pkg::MAX_VERSION)
			&& (req.zoom <= qtol_pkg::MAX_ZOOM);
		loc_idx   = qtol_pkg::quad_index(dz[2:0], req.tile_x[4:0], req.tile_y[4:0]);
	end

	// Next state and control
	always_comb begin
		state_d      = state_q;
		rd_en        = 1'b0;
		rd_addr      = scan_addr_q;
		mem_we       = 1'b0;
		scan_step    = 1'b0;
		locate_start = 1'b0;
		out_load     = 1'b0;
		fin          = 1'b0;
		fin_status   = qtol_pkg::ST_ERROR;
		fin_off      = '0;
		fin_len      = '0;
		unique case (state_q)
			qtol_pkg::LOC_IDLE: begin
				if (req_xfer) begin
					if (req.cmd == qtol_pkg::CMD_LOAD) begin
						mem_we = (req.load_index < qtol_pkg::ENTRY_COUNT);
					end else begin
						locate_start = 1'b1;
						if (locate_ok) begin
							rd_en   = 1'b1;
							rd_addr = loc_idx;
							state_d = qtol_pkg::LOC_ENTRY;
						end else begin
							state_d = qtol_pkg::LOC_DONE;
						end
					end
				end
			end
			qtol_pkg::LOC_ENTRY: begin
				if (rd_data_q < qtol_pkg::MIN_REAL_OFFSET) begin
					fin        = 1'b1;
					fin_status = 3'(rd_data_q);
					state_d    = qtol_pkg::LOC_DONE;
				end else if (pend_q.tile_index == qtol_pkg::LAST_ENTRY) begin
					fin     = 1'b1;
					state_d = qtol_pkg::LOC_DONE;
				end else begin
					rd_en     = 1'b1;
					scan_step = 1'b1;
					state_d   = qtol_pkg::LOC_SCAN;
				end
			end
			qtol_pkg::LOC_SCAN: begin
				if (rd_data_q > qtol_pkg::MIN_REAL_OFFSET) begin
					// length is nonzero and the tile fits only if offset < next <= size
					fin     = 1'b1;
					state_d = qtol_pkg::LOC_DONE;
					if (rd_data_q > entry_q && rd_data_q <= tileset_bytes_q) begin
						fin_status = qtol_pkg::ST_FOUND;
						fin_off    = entry_q;
						fin_len    = rd_data_q - entry_q;
					end
				end else if (last_issued_q) begin
					fin     = 1'b1;
					state_d = qtol_pkg::LOC_DONE;
				end else begin
					rd_en     = 1'b1;
					scan_step = 1'b1;
				end
			end
			qtol_pkg::LOC_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					out_load = 1'b1;
					state_d  = qtol_pkg::LOC_IDLE;
				end
			end
			default: state_d = qtol_pkg::LOC_IDLE;
		endcase
	end

	// State and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= qtol_pkg::LOC_IDLE;
			tileset_bytes_q  <= '0;
			header_version_q <= '0;
			rsp_valid_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					qtol_pkg::CFG_TILESET_BYTES:  tileset_bytes_q  <= cfg_data;
					qtol_pkg::CFG_HEADER_VERSION: header_version_q <= cfg_data[7:0];
					default: ;
				endcase
			end
			// hold the result until the transfer, then drop valid
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Offset table: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[req.load_index] <= req.load_value;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	// Scan pointer, tile entry and pending result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_addr_q   <= '0;
			last_issued_q <= 1'b0;
		end else if (locate_start) begin
			scan_addr_q   <= loc_idx + qtol_pkg::ENTRY_W'(1);
			last_issued_q <= 1'b0;
		end else if (scan_step) begin
			scan_addr_q   <= scan_addr_q + qtol_pkg::ENTRY_W'(1);
			last_issued_q <= (scan_addr_q == qtol_pkg::LAST_ENTRY);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == qtol_pkg::LOC_ENTRY) begin
			entry_q <= rd_data_q;
		end
		if (locate_start) begin
			pend_q.status      <= qtol_pkg::ST_ERROR;
			pend_q.tile_index  <= locate_ok ? loc_idx : '0;
			pend_q.base_zoom   <= bz;
			pend_q.base_x      <= req.tile_x >> dz;
			pend_q.base_y      <= req.tile_y >> dz;
			pend_q.tile_offset <= '0;
			pend_q.tile_length <= '0;
		end else if (fin) begin
			pend_q.status      <= fin_status;
			pend_q.tile_offset <= fin_off;
			pend_q.tile_length <= fin_len;
		end
		if (out_load) begin
			rsp_q <= pend_q;
		end
	end

endmodule

// ----- hw/rtl/qtol_checker.sv -----
// ----------------------------------------------------------------------------
// Quadtree tile offset locator checker
// Port-level properties of the locator, attached to the top level by bind.
// ----------------------------------------------------------------------------
module qtol_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_stall,
	input qtol_pkg::qtol_req_t req,
	input logic                rsp_valid,
	input logic                rsp_stall,
	input qtol_pkg::qtol_rsp_t rsp
);

	// Hold a stalled result unchanged
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed or dropped");

	// Block new requests while a locate is in work
	a_locate_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req.cmd == qtol_pkg::CMD_LOCATE |=> req_stall)
		else $error("request taken while a locate is in work");

	// Offset and length are zero unless the tile is found
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != qtol_pkg::ST_FOUND
		|-> rsp.tile_offset == '0 && rsp.tile_length == '0)
		else $error("offset or length set without a found tile");

	// Report only defined status codes and base zooms
	a_codes: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.status <= qtol_pkg::ST_ERROR
		&& (rsp.base_zoom == qtol_pkg::BASE_ZOOM_LO
		|| rsp.base_zoom == qtol_pkg::BASE_ZOOM_MID
		|| rsp.base_zoom == qtol_pkg::BASE_ZOOM_HI))
		else $error("undefined status or base zoom");

	// A found tile has a nonzero length
	a_found_len: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == qtol_pkg::ST_FOUND |-> rsp.tile_length != '0)
		else $error("found tile with zero length");

endmodule

bind quadtree_tile_offset_locator_unit qtol_checker u_qtol_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// Quadtree tile offset locator testbench
// Loads the low part of the offset table and its last two entries, then runs
// directed locates (status codes, zoom extremes, scan end, bad lengths,
// ignored loads), sweeps the file size and header version registers through
// their extremes, and finishes with random load/locate traffic under random
// idling and one long output hold-off. Random locates stay in the loaded part
// of the table, and the entries just past their reach always hold real
// offsets, so every scan stops on a loaded word. Every locate is predicted
// from a local copy of the table and registers and compared field by field.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          WATCHDOG_LIMIT  = 8000;
	localparam int          HOLD_OFF_CYCLES = 300;
	localparam int          LOAD_SETTLE     = 8;
	localparam int          PHASE_ITEMS     = 64;
	localparam int          OFFSET_STEP     = 64;
	// random locates go at most 3 quadtree levels below the base: indexes 0..84
	localparam int          MAX_REACH_DZ    = 3;
	localparam int          REACH_ENTRIES   = 85;
	localparam int          FILL_ENTRIES    = 96;
	localparam logic [31:0] FILL_TOP        = qtol_pkg::MIN_FILE_BYTES
		+ 32'(FILL_ENTRIES * OFFSET_STEP);

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  req_valid  = 1'b0;
	logic                  req_stall;
	qtol_pkg::qtol_req_t   req        = '0;
	logic                  rsp_valid;
	logic                  rsp_stall  = 1'b0;
	qtol_pkg::qtol_rsp_t   rsp;
	logic                  cfg_valid  = 1'b0;
	logic                  cfg_ready;
	logic                  cfg_index  = qtol_pkg::CFG_TILESET_BYTES;
	logic [31:0]           cfg_data   = '0;

	// Local copy of the block's table and registers
	logic [31:0] offset_shadow [qtol_pkg::TABLE_ENTRIES];
	logic [31:0] file_bytes  = '0;
	logic [7:0]  hdr_version = '0;

	qtol_pkg::qtol_rsp_t expected_locations [$];
	int          mismatches   = 0;
	int          quiet_cycles = 0;
	bit          gaps_on      = 1'b1;
	bit          stall_on     = 1'b1;
	bit          hold_off_req = 1'b0;

	quadtree_tile_offset_locator_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Pick tileset and index, read the entry, pair it with the next real offset
	function automatic qtol_pkg::qtol_rsp_t locate_tile(input qtol_pkg::qtol_req_t q);
		qtol_pkg::qtol_rsp_t r;
		int unsigned dz, prefix, mask, idx, j;
		logic [31:0] word, span;
		r = '0;
		r.status = qtol_pkg::ST_ERROR;
		if (q.zoom < qtol_pkg::ZOOM_MID_MIN) r.base_zoom = qtol_pkg::BASE_ZOOM_LO;
		else if (q.zoom > qtol_pkg::ZOOM_MID_MAX) r.base_zoom = qtol_pkg::BASE_ZOOM_HI;
		else r.base_zoom = qtol_pkg::BASE_ZOOM_MID;
		dz = 32'(q.zoom) - 32'(r.base_zoom);
		r.base_x = q.tile_x >> dz;
		r.base_y = q.tile_y >> dz;
		if (file_bytes < qtol_pkg::MIN_FILE_BYTES || hdr_version > qtol_pkg::MAX_VERSION
			|| q.zoom > qtol_pkg::MAX_ZOOM)
			return r;
		prefix = 0;
		for (j = 0; j < dz; j++) prefix += 1 << (2 * j);
		mask = (1 << dz) - 1;
		idx = prefix + ((32'(q.tile_y) & mask) << dz) + (32'(q.tile_x) & mask);
		r.tile_index = qtol_pkg::ENTRY_W'(idx);
		word = offset_shadow[idx];
		if (word < qtol_pkg::MIN_REAL_OFFSET) begin
			r.status = word[2:0];
			return r;
		end
		// scan forward for the next entry above the real-offset floor
		span = '0;
		for (j = idx + 1; j < qtol_pkg::TABLE_ENTRIES; j++) begin
			if (offset_shadow[j] > qtol_pkg::MIN_REAL_OFFSET) begin
				span = offset_shadow[j] - word;
				break;
			end
		end
		if (span != 0 && {1'b0, word} + {1'b0, span} <= {1'b0, file_bytes}) begin
			r.status      = qtol_pkg::ST_FOUND;
			r.tile_offset = word;
			r.tile_length = span;
		end
		return r;
	endfunction

	// Mostly short idle stretches, a few long ones
	function automatic int unsigned idle_span();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) return $urandom_range(1, 2);
		if (roll < 90) return $urandom_range(3, 8);
		return $urandom_range(20, 60);
	endfunction

	// Increasing offset near the entry's slot, random low bits
	function automatic logic [31:0] slot_offset(input int unsigned index);
		return qtol_pkg::MIN_FILE_BYTES + 32'(index * OFFSET_STEP)
			+ 32'($urandom_range(0, OFFSET_STEP - 1));
	endfunction

	// Codes only where locates can land; real offsets past their reach
	function automatic logic [31:0] fill_value(input int unsigned index);
		if (index < REACH_ENTRIES && $urandom_range(0, 9) == 0)
			return $urandom_range(0, qtol_pkg::MIN_REAL_OFFSET);
		return slot_offset(index);
	endfunction

	function automatic qtol_pkg::qtol_req_t make_load(input logic [10:0] index,
		input logic [31:0] value);
		qtol_pkg::qtol_req_t q;
		q.cmd        = qtol_pkg::CMD_LOAD;
		q.load_index = index;
		q.load_value = value;
		q.zoom       = 5'($urandom);
		q.tile_x     = 17'($urandom);
		q.tile_y     = 17'($urandom);
		return q;
	endfunction

	function automatic qtol_pkg::qtol_req_t make_locate(input logic [4:0] zoom,
		input logic [16:0] x, input logic [16:0] y);
		qtol_pkg::qtol_req_t q;
		q.cmd        = qtol_pkg::CMD_LOCATE;
		q.load_index = 11'($urandom);
		q.load_value = $urandom;
		q.zoom       = zoom;
		q.tile_x     = x;
		q.tile_y     = y;
		return q;
	endfunction

	// Zoom a few levels under any base, or beyond the pyramid
	function automatic qtol_pkg::qtol_req_t random_locate();
		logic [3:0]  base;
		logic [4:0]  zoom;
		int unsigned pick;
		if ($urandom_range(0, 99) < 85) begin
			pick = $urandom_range(0, 2);
			if (pick == 0) base = qtol_pkg::BASE_ZOOM_LO;
			else if (pick == 1) base = qtol_pkg::BASE_ZOOM_MID;
			else base = qtol_pkg::BASE_ZOOM_HI;
			zoom = 5'(base) + 5'($urandom_range(0, MAX_REACH_DZ));
		end else begin
			zoom = 5'($urandom_range(32'(qtol_pkg::MAX_ZOOM) + 1, 31));
		end
		return make_locate(zoom, 17'($urandom), 17'($urandom));
	endfunction

	function automatic qtol_pkg::qtol_req_t random_request();
		logic [10:0] index;
		int unsigned roll;
		logic [31:0] value;
		if ($urandom_range(0, 99) >= 35) return random_locate();
		if ($urandom_range(0, 99) < 5) index = 11'($urandom_range(qtol_pkg::TABLE_ENTRIES, 2047));
		else index = 11'($urandom_range(0, FILL_ENTRIES - 1));
		roll = $urandom_range(0, 99);
		if (index >= REACH_ENTRIES) value = slot_offset(32'(index));
		else if (roll < 15) value = $urandom_range(0, qtol_pkg::MIN_REAL_OFFSET);
		else if (roll < 30) value = $urandom;
		else value = slot_offset(32'(index));
		return make_load(index, value);
	endfunction

	// Offer one request, hold it until transfer, then update the local model
	task automatic send_item(input qtol_pkg::qtol_req_t q);
		int unsigned gap;
		gap = (gaps_on && $urandom_range(0, 2) == 0) ? idle_span() : 0;
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= q;
		do @(posedge clk); while (req_stall !== 1'b0);
		if (q.cmd == qtol_pkg::CMD_LOCATE) expected_locations.push_back(locate_tile(q));
		else if (q.load_index < qtol_pkg::TABLE_ENTRIES) offset_shadow[q.load_index] = q.load_value;
	endtask

	// Drop valid, drain all pending results, let a trailing load finish
	task automatic quiesce();
		req_valid <= 1'b0;
		while (expected_locations.size() != 0) @(posedge clk);
		repeat (LOAD_SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic index, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		if (index == qtol_pkg::CFG_TILESET_BYTES) file_bytes = data;
		else hdr_version = data[7:0];
		@(posedge clk);
	endtask

	task automatic set_registers(input logic [31:0] size, input logic [7:0] version);
		quiesce();
		write_reg(qtol_pkg::CFG_TILESET_BYTES, size);
		write_reg(qtol_pkg::CFG_HEADER_VERSION, 32'(version));
	endtask

	// Load every entry that a locate of this bench can read
	task automatic test_table_fill();
		int unsigned i;
		for (i = 0; i < FILL_ENTRIES; i++) send_item(make_load(11'(i), fill_value(i)));
		send_item(make_load(qtol_pkg::LAST_ENTRY - 11'd1,
			slot_offset(32'(qtol_pkg::LAST_ENTRY) - 1)));
		send_item(make_load(qtol_pkg::LAST_ENTRY, slot_offset(32'(qtol_pkg::LAST_ENTRY))));
	endtask

	task automatic test_directed_cases();
		logic [4:0] zoom_edges [8] = '{5'd0, 5'd5, 5'd6, 5'd11, 5'd12, 5'd17, 5'd18, 5'd31};
		int         k;
		set_registers('1, qtol_pkg::MAX_VERSION);
		// base zoom boundaries and zoom beyond the pyramid
		send_item(make_locate(5'd0, '0, '0));
		for (k = 0; k < 8; k++) send_item(make_locate(zoom_edges[k], '1, '1));
		// empty, sea, land and transparent codes at the root entry
		for (k = qtol_pkg::ST_EMPTY; k <= qtol_pkg::ST_TRANSPARENT; k++) begin
			send_item(make_load(11'd0, 32'(k)));
			send_item(make_locate(5'd0, '0, '0));
		end
		// an entry of exactly four is a real offset
		send_item(make_load(11'd0, qtol_pkg::MIN_REAL_OFFSET));
		send_item(make_load(11'd1, 32'd100));
		send_item(make_locate(5'd0, '0, '0));
		// next offset below this one, then equal to it
		send_item(make_load(11'd0, 32'd1000));
		send_item(make_load(11'd1, 32'd500));
		send_item(make_locate(5'd0, '0, '0));
		send_item(make_load(11'd1, 32'd1000));
		send_item(make_locate(5'd0, '0, '0));
		// scan stops at the last entry
		send_item(make_load(qtol_pkg::LAST_ENTRY - 11'd1, 32'd5000));
		send_item(make_load(qtol_pkg::LAST_ENTRY, 32'(qtol_pkg::ST_TRANSPARENT)));
		send_item(make_locate(5'd17, '1, '1));
		send_item(make_load(qtol_pkg::LAST_ENTRY, 32'd6000));
		send_item(make_locate(5'd17, '1, '1));
		// out-of-range loads leave the table alone
		send_item(make_load(qtol_pkg::ENTRY_COUNT, '1));
		send_item(make_load('1, '0));
		send_item(make_locate(5'd0, '0, '0));
	endtask

	// File size just below and at the minimum, version limits, empty file
	task automatic test_register_extremes();
		logic [31:0] sizes    [5] = '{qtol_pkg::MIN_FILE_BYTES - 32'd1,
			qtol_pkg::MIN_FILE_BYTES, '1, '1, '0};
		logic [7:0]  versions [5] = '{qtol_pkg::MAX_VERSION, 8'd0,
			qtol_pkg::MAX_VERSION + 8'd1, 8'hFF, 8'd1};
		int          k, n;
		for (k = 0; k < 5; k++) begin
			set_registers(sizes[k], versions[k]);
			for (n = 0; n < 4; n++) send_item(random_locate());
		end
	endtask

	task automatic test_random_traffic();
		int phase, n;
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					set_registers('1, 8'd0);
				end
				1: begin
					set_registers($urandom_range(qtol_pkg::MIN_FILE_BYTES, FILL_TOP + 200), 8'd1);
				end
				2: begin
					// a stretch with no idling on either side
					gaps_on  = 1'b0;
					stall_on = 1'b0;
					set_registers('1, qtol_pkg::MAX_VERSION);
				end
				default: begin
					gaps_on  = 1'b1;
					stall_on = 1'b1;
					set_registers($urandom,
						8'($urandom_range(0, 32'(qtol_pkg::MAX_VERSION) + 1)));
				end
			endcase
			for (n = 0; n < PHASE_ITEMS; n++) send_item(random_request());
		end
	endtask

	// Long output hold-off while requests keep coming, so the input backs up
	task automatic test_output_hold_off();
		int n;
		set_registers('1, qtol_pkg::MAX_VERSION);
		gaps_on      = 1'b0;
		hold_off_req = 1'b1;
		for (n = 0; n < 12; n++) send_item(random_locate());
		wait (hold_off_req == 1'b0);
		gaps_on = 1'b1;
	endtask

	// Receiver pacing: random stalls, or one long hold-off on request
	initial begin : receiver_pacing
		int unsigned span;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				rsp_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				rsp_stall <= 1'b0;
				hold_off_req = 1'b0;
			end else if (stall_on && $urandom_range(0, 3) == 0) begin
				span = idle_span();
				rsp_stall <= 1'b1;
				repeat (span) @(posedge clk);
				rsp_stall <= 1'b0;
			end
		end
	end

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endfunction

	// Compare each result transfer with the oldest prediction
	always @(posedge clk) begin : result_check
		qtol_pkg::qtol_rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_locations.size() == 0) begin
				$error("result transfer with no locate pending");
				mismatches++;
			end else begin
				want = expected_locations.pop_front();
				check_field("status", 32'(want.status), 32'(rsp.status));
				check_field("tile_index", 32'(want.tile_index), 32'(rsp.tile_index));
				check_field("base_zoom", 32'(want.base_zoom), 32'(rsp.base_zoom));
				check_field("base_x", 32'(want.base_x), 32'(rsp.base_x));
				check_field("base_y", 32'(want.base_y), 32'(rsp.base_y));
				check_field("tile_offset", want.tile_offset, rsp.tile_offset);
				check_field("tile_length", want.tile_length, rsp.tile_length);
			end
		end
	end

	// Abort when no channel has moved a transfer for too long
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_table_fill();
		test_directed_cases();
		test_register_extremes();
		test_random_traffic();
		test_output_hold_off();
		quiesce();
		if (mismatches == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/qtol_pkg.sv
hw/rtl/quadtree_tile_offset_locator_unit.sv
hw/rtl/qtol_checker.sv
tb/sv/testbench.sv
